// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/mavg_pkg.sv =====
package mavg_pkg;

    localparam int WINDOW    = 8;
    localparam int LEVEL_W   = 12;
    localparam int WIN_SHIFT = $clog2(WINDOW);
    localparam int WPOS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TOTAL_W   = LEVEL_W + WIN_SHIFT;
    localparam int QUO_W     = 14;
    localparam int DVD_W     = LEVEL_W + QUO_W;

    localparam logic [QUO_W-1:0]   FULL_SCALE = 14'd10000;
    localparam logic [LEVEL_W-1:0] DRY_RESET  = 12'd3000;
    localparam logic [LEVEL_W-1:0] WET_RESET  = 12'd1200;

    localparam logic [1:0] K_ZERO = 2'd0;
    localparam logic [1:0] K_FULL = 2'd1;
    localparam logic [1:0] K_DIV  = 2'd2;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef struct packed {
        logic [LEVEL_W-1:0] dry;
        logic [LEVEL_W-1:0] wet;
    } t_cal;

    typedef struct packed {
        logic [1:0]         kind;
        logic [LEVEL_W-1:0] avg;
        logic [LEVEL_W-1:0] num;
        logic [LEVEL_W-1:0] span;
    } t_job;

endpackage

// ===== design/mavg_front.sv =====
module mavg_front
    import mavg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cal               i_cal,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [LEVEL_W-1:0] i_sample,
    output logic               o_push,
    output t_job               o_job,
    input  logic               i_full
);

    logic [LEVEL_W-1:0] r_ring [WINDOW];
    logic [WPOS_W-1:0]  r_pos;
    logic [TOTAL_W-1:0] r_total;
    logic               r_pend;

    logic [TOTAL_W-1:0] n_total;
    logic [LEVEL_W-1:0] avg;
    logic               accept;

    assign o_ready = !r_pend;
    assign accept  = i_valid && !r_pend;
    assign n_total = r_total - TOTAL_W'(r_ring[r_pos]) + TOTAL_W'(i_sample);
    assign avg     = r_total[TOTAL_W-1:WIN_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
            r_pos   <= '0;
            r_total <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (accept) begin
                r_ring[r_pos] <= i_sample;
                r_total       <= n_total;
                r_pend        <= 1'b1;
                if (r_pos == WPOS_W'(WINDOW - 1)) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end else if (r_pend && !i_full) begin
                r_pend <= 1'b0;
            end
        end
    end

    // classify the average against the calibration levels
    always_comb begin
        o_job.avg  = avg;
        o_job.num  = i_cal.dry - avg;
        o_job.span = i_cal.dry - i_cal.wet;
        if (avg >= i_cal.dry) begin
            o_job.kind = K_ZERO;
        end else if (avg <= i_cal.wet) begin
            o_job.kind = K_FULL;
        end else begin
            o_job.kind = K_DIV;
        end
    end

    assign o_push = r_pend && !i_full;

endmodule

// ===== design/mavg_queue.sv =====
module mavg_queue
    import mavg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/mavg_back.sv =====
`include "assert_macros.svh"

module mavg_back
    import mavg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_data
);

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]         r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [LEVEL_W-1:0] r_num;
    logic [LEVEL_W-1:0] r_span;
    logic [LEVEL_W-1:0] r_avg;
    logic [LEVEL_W-1:0] r_rem;
    logic [QUO_W-1:0]   r_low;
    logic [QUO_W-1:0]   r_quo;
    logic               r_out_valid;
    logic [QUO_W-1:0]   r_moist;
    logic [LEVEL_W-1:0] r_out_avg;

    logic [DVD_W-1:0]   prod;
    logic [LEVEL_W:0]   trial;
    logic               qbit;
    logic [LEVEL_W:0]   diff;

    assign o_pop   = (r_state == S_IDLE) && !i_empty && !r_out_valid;
    assign o_valid = r_out_valid;
    assign o_data  = {{(32 - LEVEL_W - QUO_W){1'b0}}, r_out_avg, r_moist};

    assign prod  = DVD_W'(r_num) * DVD_W'(FULL_SCALE);
    assign trial = {r_rem, r_low[QUO_W-1]};
    assign diff  = trial - {1'b0, r_span};
    assign qbit  = (trial >= {1'b0, r_span});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_num  <= i_job.num;
                        r_span <= i_job.span;
                        r_avg  <= i_job.avg;
                        if (i_job.kind == K_DIV) begin
                            r_state <= S_MUL;
                        end else begin
                            r_out_avg   <= i_job.avg;
                            r_moist     <= (i_job.kind == K_FULL) ? FULL_SCALE : '0;
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    r_rem   <= prod[DVD_W-1:QUO_W];
                    r_low   <= prod[QUO_W-1:0];
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= qbit ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
                    r_low <= {r_low[QUO_W-2:0], 1'b0};
                    r_quo <= {r_quo[QUO_W-2:0], qbit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(QUO_W - 1)) begin
                        r_out_avg   <= r_avg;
                        r_moist     <= {r_quo[QUO_W-2:0], qbit};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_RST(a_rem_below_span, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_rem < r_span), "remainder not below span")
    `ASSERT_RST(a_moist_range, i_clk, i_rst_n, r_out_valid |-> (r_moist <= FULL_SCALE), "moisture out of range")
    `ASSERT_RST(a_div_done, i_clk, i_rst_n, ((r_state == S_DIV) && (r_cnt == CNT_W'(QUO_W - 1))) |=> (r_out_valid && (r_state == S_IDLE)), "division end lost")
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!r_out_valid && (r_state == S_IDLE)), "reset did not clear back end")

endmodule

// ===== design/moving_average_calibrated_percent.sv =====
// Moving-average moisture reader with dry/wet calibration.
// Input beats carry one 12-bit converter sample; output beats carry the
// moisture in hundredths of a percent (0..10000) and the window average.
// Every input beat yields exactly one output beat, in order.
// The front end adds the sample to an 8-entry ring and its running total,
// then classifies the registered average and pushes a job into a
// two-entry queue. The back end answers clamped jobs at once and runs a
// restoring divider, one quotient bit per cycle, for the rest.
// The back end takes one job at a time and pops the next only after the
// previous output beat is taken; a divided job passes through the product
// load, 14 divider steps and the output beat.
// A stalled output holds its beat; the queue keeps taking jobs until it
// fills, and s_axis_tready is low while the front end holds an unpushed job.
// Reset clears the ring, the running total and the write position, so the
// first averages include zeros, and loads dry 3000 and wet 1200.
// APB: dry_level at 0x0, wet_level at 0x4; write only while idle.
module moving_average_calibrated_percent
    import mavg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [13:0] moisture_hundredths, [25:14] window_average
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cal r_cal;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_job f_job;
    t_job q_job;

    assign pready = 1'b1;
    assign prdata = {{(32 - LEVEL_W){1'b0}}, paddr[2] ? r_cal.wet : r_cal.dry};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.dry <= DRY_RESET;
            r_cal.wet <= WET_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                r_cal.wet <= pwdata[LEVEL_W-1:0];
            end else begin
                r_cal.dry <= pwdata[LEVEL_W-1:0];
            end
        end
    end

    mavg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cal    (r_cal),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample (s_axis_tdata[LEVEL_W-1:0]),
        .o_push   (q_push),
        .o_job    (f_job),
        .i_full   (q_full)
    );

    mavg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_job),
        .o_empty (q_empty)
    );

    mavg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (q_job),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule
